### hw/rtl/lmtc_pkg.sv
// Package for the LFSR memory test checker: word types, opcodes, LFSR and
// counter helpers. No dependencies.
package lmtc_pkg;

  localparam int unsigned LfsrWidth = 24;
  localparam int unsigned DataWidth = 16;
  localparam int unsigned CountWidth = 16;

  localparam logic [LfsrWidth-1:0] LfsrToggle = 24'h80042B;
  localparam logic [LfsrWidth-1:0] LfsrOne = 24'h000001;
  localparam logic [CountWidth-1:0] CountMax = 16'hFFFF;
  localparam logic [CountWidth-1:0] CountOne = 16'h0001;

  typedef enum logic [2:0] {
    OP_BEGIN_PASS  = 3'd0,
    OP_FILL_STEP   = 3'd1,
    OP_BEGIN_CHECK = 3'd2,
    OP_CHECK_WORD  = 3'd3,
    OP_END_PASS    = 3'd4
  } lmtc_op_e;

  typedef struct packed {
    logic [2:0]           opcode;
    logic [LfsrWidth-1:0] seed;
    logic [DataWidth-1:0] read_word;
  } lmtc_in_t;

  typedef struct packed {
    logic [DataWidth-1:0]  pattern_word;
    logic                  mismatch;
    logic [CountWidth-1:0] error_count;
    logic [CountWidth-1:0] good_passes;
    logic [CountWidth-1:0] bad_passes;
    logic [CountWidth-1:0] pass_number;
  } lmtc_out_t;

  // Control from the sequencing logic to the LFSR block
  typedef struct packed {
    logic begin_pass;
    logic reload;
    logic step;
  } lmtc_lfsr_ctrl_t;

  // One Galois step: shift left, fold in the toggle mask when bit 23 falls out
  function automatic logic [LfsrWidth-1:0] lfsr_step(input logic [LfsrWidth-1:0] s);
    logic [LfsrWidth-1:0] r;
    r = {s[LfsrWidth-2:0], 1'b0};
    if (s[LfsrWidth-1]) begin
      r = r ^ LfsrToggle;
    end
    return r;
  endfunction

  function automatic logic [CountWidth-1:0] sat_inc(input logic [CountWidth-1:0] v);
    return (v == CountMax) ? CountMax : v + CountOne;
  endfunction

endpackage

### hw/rtl/lmtc_lfsr.sv
// LFSR block of the memory test checker: shift register and saved seed.
// Depends on lmtc_pkg.
module lmtc_lfsr (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  lmtc_pkg::lmtc_lfsr_ctrl_t       ctrl_i,
  input  logic [lmtc_pkg::LfsrWidth-1:0]  seed_i,
  output logic [lmtc_pkg::DataWidth-1:0]  pattern_o
);
  import lmtc_pkg::*;

  logic [LfsrWidth-1:0] state_q, state_d;
  logic [LfsrWidth-1:0] seed_q, seed_d;
  logic [LfsrWidth-1:0] seed_fix;

  // zero seed would lock the LFSR up
  assign seed_fix = (seed_i == '0) ? LfsrOne : seed_i;

  always_comb begin
    seed_d  = seed_q;
    state_d = state_q;
    if (ctrl_i.begin_pass) begin
      seed_d  = seed_fix;
      state_d = seed_fix;
    end else if (ctrl_i.reload) begin
      state_d = seed_q;
    end else if (ctrl_i.step) begin
      state_d = lfsr_step(state_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= LfsrOne;
      seed_q  <= LfsrOne;
    end else begin
      state_q <= state_d;
      seed_q  <= seed_d;
    end
  end

  // post-operation pattern, feeds the result word straight away
  assign pattern_o = state_d[DataWidth-1:0];

endmodule

### hw/rtl/lfsr_memory_test_checker.sv
// Top level of the LFSR memory test checker: sequencing, counters and the
// output register with skid stage. Depends on lmtc_pkg and lmtc_lfsr.
//
// One word in, one result word out, one word per cycle sustained while
// out_stall_i stays low. Each accepted word is handled in the cycle it
// arrives: the LFSR step, the compare against the read-back data and the
// saturating counter updates all sit between the input port and the
// result register. The output side has a result register plus one skid
// register; in_stall_o rises only when both are full, so a new word is
// taken while a finished result waits. Opcodes: begin pass (load seed,
// zero seed taken as 1), fill step, begin verify (reload saved seed),
// check word, end pass. Codes 5 to 7 change nothing and report the
// current state. All counters hold at 0xFFFF.
module lfsr_memory_test_checker (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  lmtc_pkg::lmtc_in_t  in_word_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output lmtc_pkg::lmtc_out_t out_word_o
);
  import lmtc_pkg::*;

  logic in_acc;
  logic out_free;

  lmtc_lfsr_ctrl_t         lfsr_ctrl;
  logic [DataWidth-1:0]    pattern;

  // pass bookkeeping
  logic                    failed_q, failed_d;
  logic [CountWidth-1:0]   errors_q, errors_d;
  logic [CountWidth-1:0]   good_q, good_d;
  logic [CountWidth-1:0]   bad_q, bad_d;
  logic [CountWidth-1:0]   pass_q, pass_d;
  logic                    miss;

  lmtc_out_t result;
  lmtc_out_t out_q;
  lmtc_out_t skid_q;
  logic      out_valid_q;
  logic      skid_valid_q;

  assign in_stall_o = skid_valid_q;
  assign in_acc     = in_valid_i & ~skid_valid_q;
  assign out_free   = ~out_valid_q | ~out_stall_i;

  // Opcode decode; nothing moves unless a word is taken
  always_comb begin
    lfsr_ctrl = '0;
    failed_d  = failed_q;
    errors_d  = errors_q;
    good_d    = good_q;
    bad_d     = bad_q;
    pass_d    = pass_q;
    miss      = 1'b0;
    if (in_acc) begin
      unique case (in_word_i.opcode)
        OP_BEGIN_PASS: begin
          lfsr_ctrl.begin_pass = 1'b1;
          failed_d             = 1'b0;
        end
        OP_FILL_STEP: begin
          lfsr_ctrl.step = 1'b1;
        end
        OP_BEGIN_CHECK: begin
          lfsr_ctrl.reload = 1'b1;
        end
        OP_CHECK_WORD: begin
          lfsr_ctrl.step = 1'b1;
          if (in_word_i.read_word != pattern) begin
            miss     = 1'b1;
            errors_d = sat_inc(errors_q);
            failed_d = 1'b1;
          end
        end
        OP_END_PASS: begin
          if (failed_q) begin
            bad_d = sat_inc(bad_q);
          end else begin
            good_d = sat_inc(good_q);
          end
          pass_d   = sat_inc(pass_q);
          failed_d = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  lmtc_lfsr u_lfsr (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (lfsr_ctrl),
    .seed_i    (in_word_i.seed),
    .pattern_o (pattern)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      failed_q <= 1'b0;
      errors_q <= '0;
      good_q   <= '0;
      bad_q    <= '0;
      pass_q   <= CountOne;
    end else begin
      failed_q <= failed_d;
      errors_q <= errors_d;
      good_q   <= good_d;
      bad_q    <= bad_d;
      pass_q   <= pass_d;
    end
  end

  always_comb begin
    result.pattern_word = pattern;
    result.mismatch     = miss;
    result.error_count  = errors_d;
    result.good_passes  = good_d;
    result.bad_passes   = bad_d;
    result.pass_number  = pass_d;
  end

  // Result register plus skid: the skid always holds the younger word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_free) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= in_acc;
      end else begin
        out_valid_q  <= in_acc;
      end
    end else if (in_acc) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
        if (in_acc) begin
          skid_q <= result;
        end
      end else if (in_acc) begin
        out_q <= result;
      end
    end else if (in_acc) begin
      skid_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule

### hw/rtl/lmtc_checker.sv
// Port-level checks for the LFSR memory test checker, bound to the top.
// Depends on lmtc_pkg and lfsr_memory_test_checker.
module lmtc_checker (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_stall_o,
  input  lmtc_pkg::lmtc_in_t  in_word_i,
  input  logic                out_valid_o,
  input  logic                out_stall_i,
  input  lmtc_pkg::lmtc_out_t out_word_o
);
  import lmtc_pkg::*;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_word_o))
    else $error("result word changed while stalled");

  // words come out in order, so the pass number never goes back
  a_pass_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && $past(out_valid_o) |->
      out_word_o.pass_number >= $past(out_word_o.pass_number))
    else $error("pass number went backwards");

  a_err_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && $past(out_valid_o) |->
      out_word_o.error_count >= $past(out_word_o.error_count))
    else $error("error count went backwards");

  // a mismatch is always counted
  a_miss_counted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.mismatch |->
      out_word_o.error_count != '0 && out_word_o.pass_number != '0)
    else $error("mismatch reported with zero error count");

  // a word taken while the output is empty shows up on the next cycle
  a_fast_path: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && !out_valid_o |=>
      out_valid_o && (!out_word_o.mismatch || $past(in_word_i.opcode) == OP_CHECK_WORD))
    else $error("accepted word missing from the output");

endmodule

bind lfsr_memory_test_checker lmtc_checker u_lmtc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_word_i   (in_word_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_word_o  (out_word_o)
);
